// ===== sv/hse_pkg.sv =====
// Heap sort engine package: sizes, storage types and the structs passed
// between the sequencer and the top level. No dependencies.
`default_nettype none

package hse_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    // child index 2*p+2 needs two bits more than an address
    localparam int CHILD_W   = ADDR_W + 2;

    typedef logic signed [DATA_W-1:0] value_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [CHILD_W-1:0]       child_t;

    // one write port, two registered read ports
    typedef struct packed {
        logic   we;
        addr_t  waddr;
        value_t wdata;
        addr_t  raddr_a;
        addr_t  raddr_b;
    } ram_req_t;

    // sorted value handed to the output register
    typedef struct packed {
        logic   valid;
        value_t value;
        logic   last;
    } emit_t;

endpackage

`default_nettype wire

// ===== sv/hse_intf.sv =====
// Request channels of the heap sort engine: load side and result side.
// Depends on hse_pkg.
`default_nettype none

interface hse_load_if;
    logic               valid;
    logic               ready;
    hse_pkg::value_t    sort_value;
    logic               is_last;

    modport source (output valid, output sort_value, output is_last, input ready);
    modport sink   (input valid, input sort_value, input is_last, output ready);
endinterface

interface hse_result_if;
    logic               valid;
    logic               ready;
    hse_pkg::value_t    sorted_value;
    logic               last_out;

    modport source (output valid, output sorted_value, output last_out, input ready);
    modport sink   (input valid, input sorted_value, input last_out, output ready);
endinterface

`default_nettype wire

// ===== sv/hse_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, read data
// registered. No dependencies.
`default_nettype none

module hse_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ===== sv/hse_ctrl.sv =====
// Heap sort sequencer: loads values, heapifies, extracts and streams the
// store out through the result register. Depends on hse_pkg, hse_intf.
`default_nettype none

module hse_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    hse_load_if.sink               load,
    input  wire logic              out_free,
    output hse_pkg::emit_t         emit,
    output hse_pkg::ram_req_t      ram_req,
    input  wire hse_pkg::value_t   rdata_a,
    input  wire hse_pkg::value_t   rdata_b
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_BUILD_RD,
        S_BUILD_HOLD,
        S_SIFT_RD,
        S_SIFT_CMP,
        S_SWAP_RD,
        S_SWAP_WR,
        S_EMIT_RD,
        S_EMIT_WR
    } state_t;

    state_t          state_reg,   state_next;
    hse_pkg::cnt_t   count_reg,   count_next;
    hse_pkg::cnt_t   len_reg,     len_next;
    hse_pkg::addr_t  root_reg,    root_next;
    hse_pkg::addr_t  parent_reg,  parent_next;
    hse_pkg::addr_t  idx_reg,     idx_next;
    logic            extract_reg, extract_next;
    hse_pkg::value_t hold_reg,    hold_next;

    logic            stored;
    hse_pkg::cnt_t   n_new;
    hse_pkg::child_t child0;
    hse_pkg::child_t child1;
    hse_pkg::child_t len_ext;
    logic            use_b;
    hse_pkg::value_t big;
    hse_pkg::addr_t  big_addr;
    logic            sift_done;
    logic            emit_last;

    assign stored    = count_reg < hse_pkg::CNT_W'(hse_pkg::MAX_ITEMS);
    assign n_new     = stored ? count_reg + hse_pkg::CNT_W'(1) : count_reg;
    assign child0    = {1'b0, parent_reg, 1'b1};
    assign child1    = child0 + hse_pkg::CHILD_W'(1);
    assign len_ext   = hse_pkg::CHILD_W'(len_reg);
    assign use_b     = (child1 < len_ext) && (rdata_b > rdata_a);
    assign big       = use_b ? rdata_b : rdata_a;
    assign big_addr  = use_b ? child1[hse_pkg::ADDR_W-1:0] : child0[hse_pkg::ADDR_W-1:0];
    assign emit_last = (hse_pkg::CNT_W'(idx_reg) + hse_pkg::CNT_W'(1)) == count_reg;

    assign load.ready = (state_reg == S_LOAD);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        len_next     = len_reg;
        root_next    = root_reg;
        parent_next  = parent_reg;
        idx_next     = idx_reg;
        extract_next = extract_reg;
        hold_next    = hold_reg;
        sift_done    = 1'b0;

        ram_req       = '0;
        emit.valid    = 1'b0;
        emit.value    = rdata_a;
        emit.last     = emit_last;

        unique case (state_reg)
            S_LOAD:
            begin
                ram_req.waddr = count_reg[hse_pkg::ADDR_W-1:0];
                ram_req.wdata = load.sort_value;
                if (load.valid)
                begin
                    ram_req.we = stored;
                    count_next = n_new;
                    if (load.is_last)
                    begin
                        extract_next = 1'b0;
                        len_next     = n_new;
                        idx_next     = '0;
                        if (n_new < hse_pkg::CNT_W'(2))
                        begin
                            state_next = S_EMIT_RD;
                        end
                        else
                        begin
                            root_next  = hse_pkg::ADDR_W'((n_new >> 1) - hse_pkg::CNT_W'(1));
                            state_next = S_BUILD_RD;
                        end
                    end
                end
            end
            S_BUILD_RD:
            begin
                ram_req.raddr_a = root_reg;
                state_next      = S_BUILD_HOLD;
            end
            S_BUILD_HOLD:
            begin
                hold_next   = rdata_a;
                parent_next = root_reg;
                len_next    = count_reg;
                state_next  = S_SIFT_RD;
            end
            S_SIFT_RD:
            begin
                ram_req.raddr_a = child0[hse_pkg::ADDR_W-1:0];
                ram_req.raddr_b = child1[hse_pkg::ADDR_W-1:0];
                ram_req.waddr   = parent_reg;
                ram_req.wdata   = hold_reg;
                if (child0 < len_ext)
                begin
                    state_next = S_SIFT_CMP;
                end
                else
                begin
                    // leaf reached: park the held value here
                    ram_req.we = 1'b1;
                    sift_done  = 1'b1;
                end
            end
            S_SIFT_CMP:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = parent_reg;
                if (big <= hold_reg)
                begin
                    ram_req.wdata = hold_reg;
                    sift_done     = 1'b1;
                end
                else
                begin
                    ram_req.wdata = big;
                    parent_next   = big_addr;
                    state_next    = S_SIFT_RD;
                end
            end
            S_SWAP_RD:
            begin
                ram_req.raddr_a = '0;
                ram_req.raddr_b = idx_reg;
                state_next      = S_SWAP_WR;
            end
            S_SWAP_WR:
            begin
                // top goes to the end; old end value sifts down from the root
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg;
                ram_req.wdata = rdata_a;
                hold_next     = rdata_b;
                parent_next   = '0;
                len_next      = hse_pkg::CNT_W'(idx_reg);
                extract_next  = 1'b1;
                state_next    = S_SIFT_RD;
            end
            S_EMIT_RD:
            begin
                ram_req.raddr_a = idx_reg;
                if (out_free)
                begin
                    state_next = S_EMIT_WR;
                end
            end
            S_EMIT_WR:
            begin
                emit.valid = 1'b1;
                if (emit_last)
                begin
                    count_next = '0;
                    state_next = S_LOAD;
                end
                else
                begin
                    idx_next   = idx_reg + hse_pkg::ADDR_W'(1);
                    state_next = S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        if (sift_done)
        begin
            if (!extract_reg)
            begin
                if (root_reg == '0)
                begin
                    idx_next   = hse_pkg::ADDR_W'(count_reg - hse_pkg::CNT_W'(1));
                    state_next = S_SWAP_RD;
                end
                else
                begin
                    root_next  = root_reg - hse_pkg::ADDR_W'(1);
                    state_next = S_BUILD_RD;
                end
            end
            else if (len_reg == hse_pkg::CNT_W'(1))
            begin
                idx_next   = '0;
                state_next = S_EMIT_RD;
            end
            else
            begin
                idx_next   = idx_reg - hse_pkg::ADDR_W'(1);
                state_next = S_SWAP_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            count_reg   <= '0;
            extract_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            extract_reg <= extract_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg    <= len_next;
        root_reg   <= root_next;
        parent_reg <= parent_next;
        idx_reg    <= idx_next;
        hold_reg   <= hold_next;
    end

endmodule

`default_nettype wire

// ===== sv/heap_sort_engine.sv =====
// Heap sort engine top level: sequencer, value RAM and result register.
// Depends on hse_pkg, hse_intf, hse_ram, hse_ctrl.
`default_nettype none

// Values arrive one per request on load and are stored until the request
// flagged is_last; at most MAX_ITEMS (64) are kept, later ones are dropped.
// Loading accepts one request per cycle. The set of n values is then sorted
// in place in a two-read, one-write RAM: the heap build sifts down
// n/2 roots and extraction runs n-1 swap-and-sift passes; each sift level
// reads both children, then compares and writes back; at a leaf the held
// value is written directly. Each swap reads the top and end, then writes
// the top to the end, and each build root is read, then held. Results
// then leave in ascending order, each read from the RAM and then written
// to the result register when result is free, with last_out on the final
// one. load is not ready from the is_last request until the final result
// has entered the result register.
module heap_sort_engine (
    input  wire logic clk,
    input  wire logic rst_n,
    hse_load_if.sink     load,
    hse_result_if.source result
);

    hse_pkg::ram_req_t ram_req;
    hse_pkg::value_t   rdata_a;
    hse_pkg::value_t   rdata_b;
    hse_pkg::emit_t    emit;
    logic              out_free;

    logic              out_valid_reg;
    hse_pkg::value_t   out_value_reg;
    logic              out_last_reg;

    assign out_free = !out_valid_reg || result.ready;

    hse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .out_free (out_free),
        .emit     (emit),
        .ram_req  (ram_req),
        .rdata_a  (rdata_a),
        .rdata_b  (rdata_b)
    );

    hse_ram #(
        .DEPTH (hse_pkg::MAX_ITEMS),
        .WIDTH (hse_pkg::DATA_W)
    ) u_ram (
        .clk     (clk),
        .we      (ram_req.we),
        .waddr   (ram_req.waddr),
        .wdata   (ram_req.wdata),
        .raddr_a (ram_req.raddr_a),
        .raddr_b (ram_req.raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_value_reg <= emit.value;
            out_last_reg  <= emit.last;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.sorted_value = out_value_reg;
    assign result.last_out     = out_last_reg;

endmodule

`default_nettype wire

// ===== bench/sort_checker.sv =====
// Scoreboard for the heap sort engine: watches the load and result channels,
// predicts the ascending output of every set and compares it field by field.
// Depends on hse_pkg and hse_intf.
`timescale 1ns / 1ps

module sort_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    hse_load_if       load,
    hse_result_if     result,
    output int        error_count,
    output int        results_owed
);

    typedef struct packed {
        hse_pkg::value_t value;
        logic            last;
    } sorted_result_t;

    hse_pkg::value_t held_q[$];      // values of the set being loaded
    sorted_result_t  ascending_q[$]; // sorted results still to come out
    int              mismatches;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // in-place ascending sort of the held set
    function automatic void sort_held();
        int              i;
        int              j;
        hse_pkg::value_t key;
        for (i = 1; i < held_q.size(); i++)
        begin
            key = held_q[i];
            j   = i - 1;
            while (j >= 0 && held_q[j] > key)
            begin
                held_q[j + 1] = held_q[j];
                j--;
            end
            held_q[j + 1] = key;
        end
    endfunction

    always @(posedge clk)
    begin : watch
        sorted_result_t want;
        int             k;
        if (rst_n)
        begin
            if (load.valid && load.ready)
            begin
                // store full: the request's value is dropped
                if (held_q.size() < hse_pkg::MAX_ITEMS)
                    held_q.push_back(load.sort_value);
                if (load.is_last)
                begin
                    sort_held();
                    for (k = 0; k < held_q.size(); k++)
                    begin
                        want.value = held_q[k];
                        want.last  = (k == held_q.size() - 1);
                        ascending_q.push_back(want);
                    end
                    held_q.delete();
                end
            end
            if (result.valid && result.ready)
            begin
                if (ascending_q.size() == 0)
                    report_mismatch($sformatf("unexpected result value=%0d last=%b",
                                              result.sorted_value, result.last_out));
                else
                begin
                    want = ascending_q.pop_front();
                    if (result.sorted_value !== want.value || result.last_out !== want.last)
                        report_mismatch($sformatf("result value=%0d last=%b, want %0d/%b",
                                                  result.sorted_value, result.last_out,
                                                  want.value, want.last));
                end
            end
        end
        error_count  <= mismatches;
        results_owed <= ascending_q.size() + held_q.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the heap sort engine testbench: clock, reset, load requests and
// result back-pressure; sort_checker does the prediction and comparison.
// Depends on hse_pkg, hse_intf, heap_sort_engine and sort_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int  TARGET_ITEMS = 460;
    localparam int  LONG_HOLD    = 500;
    localparam int  CYCLE_LIMIT  = 1000000;

    logic clk;
    logic rst_n;
    int   error_count;
    int   results_owed;
    int   items_sent;
    int   cycle_count;
    bit   burst_mode;
    bit   hold_req;
    hse_pkg::value_t set_q[$];

    hse_load_if   load_ch ();
    hse_result_if result_ch ();

    heap_sort_engine u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load_ch),
        .result (result_ch)
    );

    sort_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load_ch),
        .result       (result_ch),
        .error_count  (error_count),
        .results_owed (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // mostly short gaps, a few long ones; none in burst stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic hse_pkg::value_t pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
                return hse_pkg::value_t'($urandom());
            6, 7:
                return hse_pkg::value_t'($urandom_range(0, 16)) - hse_pkg::value_t'(8);
            8:
                return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default:
                return $urandom_range(0, 1)
                    ? hse_pkg::value_t'(32'sh7FFFFFF0 + $urandom_range(0, 15))
                    : hse_pkg::value_t'(32'sh80000000 + $urandom_range(0, 15));
        endcase
    endfunction

    task automatic send_request(input hse_pkg::value_t v, input logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            load_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        load_ch.valid      <= 1'b1;
        load_ch.sort_value <= v;
        load_ch.is_last    <= lst;
        do
            @(posedge clk);
        while (!(load_ch.valid && load_ch.ready));
        items_sent++;
    endtask

    task automatic send_queued_set();
        int k;
        for (k = 0; k < set_q.size(); k++)
            send_request(set_q[k], k == set_q.size() - 1);
    endtask

    task automatic send_random_set(input int count);
        int k;
        for (k = 0; k < count; k++)
            send_request(pick_value(), k == count - 1);
    endtask

    function automatic int pick_set_size();
        case ($urandom_range(0, 19))
            0:          return hse_pkg::MAX_ITEMS;
            1:          return $urandom_range(hse_pkg::MAX_ITEMS + 1, hse_pkg::MAX_ITEMS + 3);
            2, 3, 4:    return $urandom_range(17, 40);
            default:    return $urandom_range(1, 16);
        endcase
    endfunction

    // result side: random stalls, plus one long hold-off on request
    initial
    begin : ready_gen
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        result_ch.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done  = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        items_sent = 0;
        burst_mode = 1'b0;
        hold_req   = 1'b0;
        rst_n              <= 1'b0;
        load_ch.valid      <= 1'b0;
        load_ch.sort_value <= '0;
        load_ch.is_last    <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-value sets at both extremes
        set_q = '{32'sh7FFFFFFF};
        send_queued_set();
        set_q = '{32'sh80000000};
        send_queued_set();
        // mixed signs, extremes and a repeated value
        set_q = '{0, -1, 1, 32'sh7FFFFFFF, 32'sh80000000, 5, 5, -5};
        send_queued_set();
        set_q = '{3, 3};
        send_queued_set();
        set_q = '{9, 7, 5, 3, 1, -1, -3};
        send_queued_set();
        set_q = '{-2, 0, 2, 4};
        send_queued_set();

        // exactly full, then overflow with is_last on a dropped value
        send_random_set(hse_pkg::MAX_ITEMS);
        send_random_set(hse_pkg::MAX_ITEMS + 6);

        // results held back while the next set is offered
        send_random_set(24);
        hold_req = 1'b1;
        send_random_set(30);

        while (items_sent < TARGET_ITEMS)
        begin
            burst_mode = ($urandom_range(0, 5) == 0);
            send_random_set(pick_set_size());
        end
        burst_mode = 1'b0;
        load_ch.valid <= 1'b0;

        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0 && results_owed == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
